/* design/gra_pkg.sv */
// Shared types, constants and pipeline depths for the GELU/ReLU activation core.
// No dependencies; every design file imports this package.
package gra_pkg;

    // Transaction payloads
    typedef struct packed {
        logic signed [31:0] sample;
        logic               last_in;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] activated;
        logic               last_out;
    } out_item_t;

    // Activation mode codes
    localparam logic MODE_GELU = 1'b0;
    localparam logic MODE_RELU = 1'b1;

    // Fixed-point constants (Q16.16 unless noted; LN2_RECIP is 1/ln 2 in Q1.20)
    localparam logic [32:0] FOUR_Q16   = 33'd262144;
    localparam logic [18:0] FIVE_Q16   = 19'd327680;
    localparam logic [19:0] C_CUBIC    = 20'd750193;     // 0.044715 in Q8.24
    localparam logic [23:0] C_SQRT2PI  = 24'd13386282;   // 0.7978845608 in Q8.24
    localparam logic [15:0] LN2_Q16    = 16'd45426;
    localparam logic [20:0] LN2_RECIP  = 21'((64'd1 << 36) / 64'd45426);
    localparam logic [30:0] H_ONE      = 31'd1073741824; // 1.0 in Q2.30
    localparam logic [16:0] T_ONE      = 17'd65536;

    // Pipeline depths
    localparam int HORN_STEPS = 8;
    localparam int HORN_LAT   = 3 * HORN_STEPS;
    localparam int DIV_BITS   = 17;
    localparam int SB_LEN     = HORN_LAT + 1 + DIV_BITS;

    // Sideband carried alongside the tanh datapath
    typedef struct packed {
        logic [31:0] x;
        logic        last;
        logic        mode;
        logic        big;
        logic [3:0]  n;
    } side_t;

endpackage

/* design/gra_horner.sv */
// Pipelined Horner evaluation of e^(-r) in Q2.30, three stages per step.
// Depends on gra_pkg.
module gra_horner (
    input  logic        clk,
    input  logic        en,
    input  logic [15:0] r_in,
    output logic [30:0] h_out
);
    import gra_pkg::*;

    logic [29:0] p_a_reg [HORN_STEPS];
    logic [15:0] r_a_reg [HORN_STEPS];
    logic [29:0] p_b_reg [HORN_STEPS];
    logic [29:0] q_b_reg [HORN_STEPS];
    logic [15:0] r_b_reg [HORN_STEPS];
    logic [30:0] h_c_reg [HORN_STEPS];
    logic [15:0] r_c_reg [HORN_STEPS];

    genvar j;
    generate
        for (j = 0; j < HORN_STEPS; j++)
        begin : g_step
            localparam int K = HORN_STEPS - j;
            logic [30:0] h_in;
            logic [15:0] r_cur;
            logic [46:0] prod_a;
            logic [29:0] q_est;
            logic [29:0] rem_c;
            logic [29:0] q_fix;

            if (j == 0)
            begin : g_first
                assign h_in  = H_ONE;
                assign r_cur = r_in;
            end
            else
            begin : g_next
                assign h_in  = h_c_reg[j-1];
                assign r_cur = r_c_reg[j-1];
            end

            // Multiply the remainder by the running value
            assign prod_a = 47'(r_cur) * 47'(h_in);

            // Divide by the step constant
            if ((K & (K - 1)) == 0)
            begin : g_pow2
                assign q_est = p_a_reg[j] >> $clog2(K);
            end
            else
            begin : g_recip
                localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(K));
                logic [61:0] prod_b;
                assign prod_b = 62'(p_a_reg[j]) * 62'(RECIP);
                assign q_est  = prod_b[61:32];
            end

            // Correct the quotient estimate by one
            assign rem_c = p_b_reg[j] - 30'(q_b_reg[j] * 30'(K));
            assign q_fix = (rem_c >= 30'(K)) ? q_b_reg[j] + 30'd1 : q_b_reg[j];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    p_a_reg[j] <= prod_a[45:16];
                    r_a_reg[j] <= r_cur;
                    p_b_reg[j] <= p_a_reg[j];
                    q_b_reg[j] <= q_est;
                    r_b_reg[j] <= r_a_reg[j];
                    h_c_reg[j] <= H_ONE - 31'(q_fix);
                    r_c_reg[j] <= r_b_reg[j];
                end
            end
        end
    endgenerate

    assign h_out = h_c_reg[HORN_STEPS-1];

endmodule

/* design/gra_div.sv */
// Pipelined restoring divider, one quotient bit per stage, for the tanh ratio.
// Depends on gra_pkg.
module gra_div (
    input  logic                         clk,
    input  logic                         en,
    input  logic [46:0]                  num,
    input  logic [31:0]                  den,
    output logic [gra_pkg::DIV_BITS-1:0] quo
);
    import gra_pkg::*;

    logic [31:0]         rem_reg [DIV_BITS];
    logic [31:0]         den_reg [DIV_BITS];
    logic [DIV_BITS-1:0] lo_reg  [DIV_BITS];
    logic [DIV_BITS-1:0] q_reg   [DIV_BITS];

    genvar i;
    generate
        for (i = 0; i < DIV_BITS; i++)
        begin : g_bit
            logic [31:0]         rem_in;
            logic [31:0]         den_in;
            logic [DIV_BITS-1:0] lo_in;
            logic [DIV_BITS-1:0] q_in;
            logic [32:0]         trial;
            logic                take;

            if (i == 0)
            begin : g_first
                assign rem_in = 32'(num[46:DIV_BITS]);
                assign den_in = den;
                assign lo_in  = num[DIV_BITS-1:0];
                assign q_in   = '0;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[i-1];
                assign den_in = den_reg[i-1];
                assign lo_in  = lo_reg[i-1];
                assign q_in   = q_reg[i-1];
            end

            // Shift in the next dividend bit and try a subtract
            assign trial = {rem_in, lo_in[DIV_BITS-1]};
            assign take  = (trial >= 33'(den_in));

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= take ? 32'(trial - 33'(den_in)) : trial[31:0];
                    den_reg[i] <= den_in;
                    lo_reg[i]  <= lo_in << 1;
                    q_reg[i]   <= {q_in[DIV_BITS-2:0], take};
                end
            end
        end
    endgenerate

    assign quo = q_reg[DIV_BITS-1];

endmodule

/* design/gelu_relu_activation_core.sv */
// GELU (tanh approximation) / ReLU activation core, top level.
// Depends on gra_pkg, gra_horner and gra_div.
//
// Usage:
//  - Input channel in_valid/in_ready/in_data carries one Q16.16 sample and a
//    last flag per transaction; output channel out_valid/out_ready/out_data
//    returns one saturated Q16.16 result with the last flag copied.
//  - cfg_wr_en/cfg_wr_data write the mode bit (0 GELU, 1 ReLU) with no wait;
//    write it only while no transactions are in flight.
//  - Throughput: one transaction per cycle sustained while out_ready is high.
//  - Pipeline from input acceptance to output valid: the cubic/scale
//    multiplies (5 stages), range reduction (2), the eight-step Horner
//    exponential (24), ratio setup (1), the 17-bit pipelined divider (17),
//    the final product (1) and the output register (1).
//  - Stall: the whole pipeline holds while the output register is full and
//    out_ready is low; in_ready drops in the same cycle, nothing is lost.
//  - Reset (rst_n low, asynchronous) empties the pipeline and selects GELU.
module gelu_relu_activation_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  gra_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output gra_pkg::out_item_t out_data,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data
);
    import gra_pkg::*;

    logic en;
    logic mode_reg;

    // Front stages
    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    side_t       s1_reg, s2_reg, s3_reg, s4_reg, s5_reg, s6_reg, s7_reg;
    logic [17:0] a1_reg, a2_reg, a3_reg, a4_reg;
    logic [19:0] x2_reg;
    logic [21:0] x3_reg;
    logic [17:0] t1_reg;
    logic [18:0] u_reg;
    logic [19:0] v_reg;
    logic [3:0]  qe_reg;
    logic [15:0] r_reg;

    // Back stages
    logic        sb_v_reg [SB_LEN];
    side_t       sb_reg   [SB_LEN];
    logic [46:0] num_reg;
    logic [31:0] den_reg;
    logic        v50_reg;
    side_t       s50_reg;
    logic [33:0] mag_reg;
    logic        out_valid_reg;
    out_item_t   out_reg;

    logic [32:0] a_in;
    logic        big_in;
    side_t       s1_next;
    logic [35:0] sq_prod;
    logic [37:0] cube_prod;
    logic [41:0] cub_prod;
    logic [18:0] s_sum;
    logic [42:0] u_prod;
    side_t       s6_next;
    logic [19:0] v_next;
    logic [40:0] qe_prod;
    logic [19:0] r0;
    logic [3:0]  n_next;
    logic [15:0] r_next;
    side_t       s7_next;
    logic [30:0] h_val;
    logic [30:0] d_val;
    logic [31:0] den_next;
    logic [46:0] num_next;
    logic [DIV_BITS-1:0] quo;
    side_t       s_end;
    logic [16:0] t_val;
    logic [32:0] a_end;
    logic [17:0] factor;
    logic [50:0] y_prod;
    logic [33:0] neg_mag;
    logic [31:0] gelu_y;
    out_item_t   out_next;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // Mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_GELU;
        else if (cfg_wr_en)
            mode_reg <= cfg_wr_data;
    end

    // Magnitude and large-input check
    assign a_in   = in_data.sample[31] ? 33'd0 - {1'b1, in_data.sample}
                                       : {1'b0, in_data.sample};
    assign big_in = (a_in >= FOUR_Q16);
    always_comb
    begin
        s1_next      = '0;
        s1_next.x    = in_data.sample;
        s1_next.last = in_data.last_in;
        s1_next.mode = mode_reg;
        s1_next.big  = big_in;
    end

    // Polynomial datapath
    assign sq_prod   = 36'(a1_reg) * 36'(a1_reg) + 36'd32768;
    assign cube_prod = 38'(x2_reg) * 38'(a2_reg) + 38'd32768;
    assign cub_prod  = 42'(x3_reg) * 42'(C_CUBIC) + 42'd8388608;
    assign s_sum     = 19'(a4_reg) + 19'(t1_reg);
    assign u_prod    = 43'(s_sum) * 43'(C_SQRT2PI) + 43'd8388608;

    // Flag an inner value above five as saturated
    always_comb
    begin
        s6_next     = s5_reg;
        s6_next.big = s5_reg.big || (u_reg > FIVE_Q16);
    end

    // Range reduction by ln 2
    assign v_next  = {u_reg, 1'b0};
    assign qe_prod = 41'(v_next) * 41'(LN2_RECIP);
    assign r0      = v_reg - 20'(qe_reg) * 20'(LN2_Q16);
    always_comb
    begin
        s7_next = s6_reg;
        if (r0 >= 20'(LN2_Q16))
        begin
            n_next = qe_reg + 4'd1;
            r_next = 16'(r0 - 20'(LN2_Q16));
        end
        else
        begin
            n_next = qe_reg;
            r_next = r0[15:0];
        end
        s7_next.n = n_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            a1_reg <= a_in[17:0];
            s2_reg <= s1_reg;
            a2_reg <= a1_reg;
            x2_reg <= sq_prod[35:16];
            s3_reg <= s2_reg;
            a3_reg <= a2_reg;
            x3_reg <= cube_prod[37:16];
            s4_reg <= s3_reg;
            a4_reg <= a3_reg;
            t1_reg <= cub_prod[41:24];
            s5_reg <= s4_reg;
            u_reg  <= u_prod[42:24];
            s6_reg <= s6_next;
            v_reg  <= v_next;
            qe_reg <= qe_prod[39:36];
            s7_reg <= s7_next;
            r_reg  <= r_next;
        end
    end

    // Exponential of the reduced argument
    gra_horner u_horner (
        .clk   (clk),
        .en    (en),
        .r_in  (r_reg),
        .h_out (h_val)
    );

    // Form the tanh ratio operands
    assign d_val    = h_val >> sb_reg[HORN_LAT-1].n;
    assign den_next = 32'(H_ONE) + 32'(d_val);
    assign num_next = (47'(H_ONE - d_val) << 16) + 47'(den_next >> 1);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= num_next;
            den_reg <= den_next;
        end
    end

    gra_div u_div (
        .clk (clk),
        .en  (en),
        .num (num_reg),
        .den (den_reg),
        .quo (quo)
    );

    // Sideband delay line alongside Horner and divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SB_LEN; i++)
                sb_v_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            sb_v_reg[0] <= v7_reg;
            for (int i = 1; i < SB_LEN; i++)
                sb_v_reg[i] <= sb_v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg[0] <= s7_reg;
            for (int i = 1; i < SB_LEN; i++)
                sb_reg[i] <= sb_reg[i-1];
        end
    end

    // Final product 0.5*x*(1 +/- t)
    assign s_end  = sb_reg[SB_LEN-1];
    assign t_val  = s_end.big ? T_ONE : quo;
    assign a_end  = s_end.x[31] ? 33'd0 - {1'b1, s_end.x} : {1'b0, s_end.x};
    assign factor = s_end.x[31] ? 18'(T_ONE) - 18'(t_val) : 18'(T_ONE) + 18'(t_val);
    assign y_prod = 51'(a_end) * 51'(factor) + 51'd65536;

    // Saturate, restore sign and pick the mode
    assign neg_mag = (mag_reg > 34'h080000000) ? 34'h080000000 : mag_reg;
    always_comb
    begin
        if (s50_reg.x[31])
            gelu_y = 32'd0 - neg_mag[31:0];
        else if (mag_reg > 34'h07FFFFFFF)
            gelu_y = 32'h7FFFFFFF;
        else
            gelu_y = mag_reg[31:0];
        out_next.last_out = s50_reg.last;
        if (s50_reg.mode == MODE_RELU)
            out_next.activated = s50_reg.x[31] ? 32'sd0 : s50_reg.x;
        else
            out_next.activated = gelu_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v50_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v50_reg       <= sb_v_reg[SB_LEN-1];
            out_valid_reg <= v50_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s50_reg <= s_end;
            mag_reg <= y_prod[50:17];
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* design/gra_checker.sv */
// Port-level checks for the activation core, attached by bind.
// Depends on gra_pkg and gelu_relu_activation_core.
module gra_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input gra_pkg::out_item_t out_data
);
    import gra_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output transaction changed while stalled");

    // Accept input exactly when the output stage can advance
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow output backpressure");

    // Drop all results at reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid right after reset");

endmodule

bind gelu_relu_activation_core gra_checker u_gra_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
